FILE: rtl/gda_pkg.sv
package gda_pkg;

    localparam int unsigned GDA_DAY_W   = 5;
    localparam int unsigned GDA_MONTH_W = 4;
    localparam int unsigned GDA_YEAR_W  = 16;
    localparam int unsigned GDA_ADD_W   = 16;
    // day of year plus up to 65535 added days
    localparam int unsigned GDA_REM_W   = 17;
    // quotient of a 16-bit year by 100 fits in 10 bits
    localparam int unsigned GDA_QUO_W   = 10;
    localparam int unsigned GDA_PROD_W  = 33;
    localparam int unsigned GDA_SHIFT   = 23;
    // ceil(2^23 / 100): exact division by 100 for any 16-bit year
    localparam logic [16:0] GDA_RECIP   = 17'd83887;

    localparam logic [GDA_MONTH_W-1:0] GDA_JAN = 4'd1;
    localparam logic [GDA_MONTH_W-1:0] GDA_FEB = 4'd2;
    localparam logic [GDA_MONTH_W-1:0] GDA_DEC = 4'd12;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_MOD,
        S_CHECK,
        S_ACC,
        S_SUB,
        S_DONE,
        S_BAD
    } t_state;

    typedef struct packed {
        logic load;
        logic prod;
        logic modc;
        logic init;
        logic acc_step;
        logic acc_add;
        logic sub_step;
        logic out_load;
        logic out_bad;
    } t_cmd;

    typedef struct packed {
        logic date_ok;
        logic at_month;
        logic fits;
    } t_sts;

    function automatic logic [GDA_DAY_W-1:0] gda_month_len(
        input logic [GDA_MONTH_W-1:0] month,
        input logic                   leap
    );
        logic [GDA_DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/gda_if.sv
interface gda_in_if;
    import gda_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [GDA_DAY_W-1:0]   start_day;
    logic [GDA_MONTH_W-1:0] start_month;
    logic [GDA_YEAR_W-1:0]  start_year;
    logic [GDA_ADD_W-1:0]   days_to_add;

    modport source (output valid, start_day, start_month, start_year, days_to_add,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                    output ready);
endinterface

interface gda_out_if;
    import gda_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [GDA_DAY_W-1:0]   result_day;
    logic [GDA_MONTH_W-1:0] result_month;
    logic [GDA_YEAR_W-1:0]  result_year;
    logic                   bad_date;

    modport source (output valid, result_day, result_month, result_year, bad_date,
                    input ready);
    modport sink   (input valid, result_day, result_month, result_year, bad_date,
                    output ready);
endinterface

FILE: rtl/gda_ctrl.sv
module gda_ctrl import gda_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PROD;
            S_PROD:  n_state = S_MOD;
            S_MOD:   n_state = S_CHECK;
            S_CHECK: n_state = i_sts.date_ok ? S_ACC : S_BAD;
            S_ACC:   if (i_sts.at_month) n_state = S_SUB;
            S_SUB:   if (i_sts.fits) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            S_BAD:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PROD:  o_cmd.prod = 1'b1;
            S_MOD:   o_cmd.modc = 1'b1;
            S_CHECK: o_cmd.init = i_sts.date_ok;
            S_ACC: begin
                o_cmd.acc_add  = i_sts.at_month;
                o_cmd.acc_step = !i_sts.at_month;
            end
            S_SUB:   o_cmd.sub_step = !i_sts.fits;
            S_DONE:  o_cmd.out_load = out_free;
            S_BAD: begin
                o_cmd.out_load = out_free;
                o_cmd.out_bad  = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/gda_dp.sv
module gda_dp import gda_pkg::*; (
    input  logic                   i_clk,
    input  t_cmd                   i_cmd,
    input  logic [GDA_DAY_W-1:0]   i_start_day,
    input  logic [GDA_MONTH_W-1:0] i_start_month,
    input  logic [GDA_YEAR_W-1:0]  i_start_year,
    input  logic [GDA_ADD_W-1:0]   i_days_to_add,
    output t_sts                   o_sts,
    output logic [GDA_DAY_W-1:0]   o_result_day,
    output logic [GDA_MONTH_W-1:0] o_result_month,
    output logic [GDA_YEAR_W-1:0]  o_result_year,
    output logic                   o_bad_date
);

    logic [GDA_DAY_W-1:0]   r_day;
    logic [GDA_MONTH_W-1:0] r_month;
    logic [GDA_YEAR_W-1:0]  r_year;
    logic [GDA_ADD_W-1:0]   r_add;
    logic [GDA_PROD_W-1:0]  r_prod;
    logic [6:0]             r_y100;   // year mod 100
    logic [1:0]             r_c4;     // (year div 100) mod 4
    logic [GDA_REM_W-1:0]   r_rem;
    logic [GDA_MONTH_W-1:0] r_m;
    logic [GDA_DAY_W-1:0]   r_o_day;
    logic [GDA_MONTH_W-1:0] r_o_month;
    logic [GDA_YEAR_W-1:0]  r_o_year;
    logic                   r_o_bad;

    logic [GDA_QUO_W-1:0]   quo;
    logic [GDA_YEAR_W-1:0]  quo_x100;
    logic [GDA_YEAR_W-1:0]  rem100;
    logic                   leap;
    logic [GDA_DAY_W-1:0]   len_start;
    logic [GDA_DAY_W-1:0]   len_cur;

    assign quo      = r_prod[GDA_SHIFT +: GDA_QUO_W];
    assign quo_x100 = (GDA_YEAR_W'(quo) << 6) + (GDA_YEAR_W'(quo) << 5)
                    + (GDA_YEAR_W'(quo) << 2);
    assign rem100   = r_year - quo_x100;

    assign leap = ((r_year[1:0] == 2'd0) && (r_y100 != 7'd0))
               || ((r_y100 == 7'd0) && (r_c4 == 2'd0));

    assign len_start = gda_month_len(r_month, leap);
    assign len_cur   = gda_month_len(r_m, leap);

    assign o_sts.date_ok  = (r_month >= GDA_JAN) && (r_month <= GDA_DEC)
                         && (r_day != '0) && (r_day <= len_start);
    assign o_sts.at_month = (r_m == r_month);
    assign o_sts.fits     = (r_rem <= GDA_REM_W'(len_cur));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day   <= i_start_day;
            r_month <= i_start_month;
            r_year  <= i_start_year;
            r_add   <= i_days_to_add;
        end
        if (i_cmd.prod) begin
            r_prod <= GDA_PROD_W'(r_year) * GDA_PROD_W'(GDA_RECIP);
        end
        if (i_cmd.modc) begin
            r_y100 <= rem100[6:0];
            r_c4   <= quo[1:0];
        end
        if (i_cmd.init) begin
            r_rem <= GDA_REM_W'(r_day);
            r_m   <= GDA_JAN;
        end
        if (i_cmd.acc_step) begin
            r_rem <= r_rem + GDA_REM_W'(len_cur);
            r_m   <= r_m + 1'b1;
        end
        if (i_cmd.acc_add) begin
            r_rem <= r_rem + GDA_REM_W'(r_add);
            r_m   <= GDA_JAN;
        end
        if (i_cmd.sub_step) begin
            r_rem <= r_rem - GDA_REM_W'(len_cur);
            if (r_m == GDA_DEC) begin
                r_m    <= GDA_JAN;
                r_year <= r_year + 1'b1;
                if (r_year == '1) begin
                    // wrap to year 0
                    r_y100 <= 7'd0;
                    r_c4   <= 2'd0;
                end else if (r_y100 == 7'd99) begin
                    r_y100 <= 7'd0;
                    r_c4   <= r_c4 + 1'b1;
                end else begin
                    r_y100 <= r_y100 + 1'b1;
                end
            end else begin
                r_m <= r_m + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_o_bad <= i_cmd.out_bad;
            if (i_cmd.out_bad) begin
                r_o_day   <= '0;
                r_o_month <= '0;
                r_o_year  <= '0;
            end else begin
                r_o_day   <= r_rem[GDA_DAY_W-1:0];
                r_o_month <= r_m;
                r_o_year  <= r_year;
            end
        end
    end

    assign o_result_day   = r_o_day;
    assign o_result_month = r_o_month;
    assign o_result_year  = r_o_year;
    assign o_bad_date     = r_o_bad;

endmodule

FILE: rtl/gregorian_date_add_days_core.sv
// Gregorian date advance.
// Input channel i_in: start_day, start_month, start_year, days_to_add.
// Output channel o_out: result_day, result_month, result_year, bad_date.
// Each accepted input transfer produces exactly one output transfer.
// An invalid month or day gives bad_date = 1 with all other fields zero.
// Steps after an input transfer: multiply the year by the reciprocal,
// take year mod 100 and century mod 4, check the date (a bad date goes
// straight to the output register), sum the day of year and days to add,
// then subtract whole months (one month subtraction per cycle).
// One date is in work at a time; i_in.ready is high only while idle.
// The result sits in an output register, so the next input is taken as
// soon as the result is loaded, even while o_out stalls. If the output
// register is still full when a new result is ready, the block waits.
// Synchronous active-low reset returns the controller to idle and drops
// o_out.valid; no item in work survives reset.
module gregorian_date_add_days_core import gda_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gda_in_if.sink        i_in,
    gda_out_if.source     o_out
);

    t_cmd cmd;
    t_sts sts;

    gda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gda_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_start_day    (i_in.start_day),
        .i_start_month  (i_in.start_month),
        .i_start_year   (i_in.start_year),
        .i_days_to_add  (i_in.days_to_add),
        .o_sts          (sts),
        .o_result_day   (o_out.result_day),
        .o_result_month (o_out.result_month),
        .o_result_year  (o_out.result_year),
        .o_bad_date     (o_out.bad_date)
    );

endmodule

FILE: rtl/gda_checker.sv
module gda_checker import gda_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [GDA_DAY_W-1:0]   i_result_day,
    input logic [GDA_MONTH_W-1:0] i_result_month,
    input logic [GDA_YEAR_W-1:0]  i_result_year,
    input logic                   i_bad_date
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while busy");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_bad_date) |->
            (i_result_day == '0) && (i_result_month == '0) && (i_result_year == '0))
        else $error("bad date result not cleared");

    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_bad_date) |->
            (i_result_day != '0) && (i_result_month >= GDA_JAN)
            && (i_result_month <= GDA_DEC))
        else $error("result date out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            i_out_valid && $stable(i_result_day) && $stable(i_result_month)
            && $stable(i_result_year) && $stable(i_bad_date))
        else $error("stalled result changed");

endmodule

bind gregorian_date_add_days_core gda_checker u_gda_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_day   (o_out.result_day),
    .i_result_month (o_out.result_month),
    .i_result_year  (o_out.result_year),
    .i_bad_date     (o_out.bad_date)
);

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gda_pkg::*;

    localparam int unsigned N_RANDOM     = 250;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned HOLD_AFTER   = 40;
    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int unsigned DRAIN_CYCLES = 50;
    localparam int unsigned RESET_CYCLES = 5;

    typedef struct packed {
        logic [GDA_DAY_W-1:0]   day;
        logic [GDA_MONTH_W-1:0] month;
        logic [GDA_YEAR_W-1:0]  year;
        logic [GDA_ADD_W-1:0]   add;
    } t_date_req;

    typedef struct packed {
        logic [GDA_DAY_W-1:0]   day;
        logic [GDA_MONTH_W-1:0] month;
        logic [GDA_YEAR_W-1:0]  year;
        logic                   bad;
    } t_date_res;

    logic clk;
    logic rst_n;
    logic hold_off = 1'b0;

    gda_in_if  in_if ();
    gda_out_if out_if ();

    gregorian_date_add_days_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_date_req   date_q[$];
    t_date_res   due_q[$];
    int unsigned n_offered = 0;
    int unsigned n_results = 0;
    int unsigned err_cnt   = 0;
    int unsigned cycle_cnt = 0;
    int unsigned in_gap;
    int unsigned out_stall;

    function automatic logic is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == GDA_FEB) begin
            return is_leap(y) ? 29 : 28;
        end
        case (m)
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic t_date_res advance_date(input t_date_req r);
        t_date_res   res;
        int unsigned yr;
        int unsigned mo;
        int unsigned left;
        res     = '0;
        res.bad = 1'b1;
        yr      = r.year;
        if (r.month < GDA_JAN || r.month > GDA_DEC || r.day == 0 ||
            r.day > days_in_month(r.month, yr)) begin
            return res;
        end
        left = r.day;
        for (int unsigned m = GDA_JAN; m < r.month; m++) begin
            left += days_in_month(m, yr);
        end
        left += r.add;
        mo = GDA_JAN;
        while (left > days_in_month(mo, yr)) begin
            left -= days_in_month(mo, yr);
            mo++;
            if (mo > GDA_DEC) begin
                mo = GDA_JAN;
                yr = (yr + 1) & 16'hFFFF;
            end
        end
        res.day   = GDA_DAY_W'(left);
        res.month = GDA_MONTH_W'(mo);
        res.year  = GDA_YEAR_W'(yr);
        res.bad   = 1'b0;
        return res;
    endfunction

    // every third block of 40 transfers runs without gaps
    function automatic int unsigned pick_gap(input int unsigned count);
        int unsigned r;
        if ((count / 40) % 3 == 2) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 150);
    endfunction

    function automatic void queue_date(
        input int unsigned d,
        input int unsigned m,
        input int unsigned y,
        input int unsigned a
    );
        date_q.push_back('{day: GDA_DAY_W'(d), month: GDA_MONTH_W'(m),
                           year: GDA_YEAR_W'(y), add: GDA_ADD_W'(a)});
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // sender
    always @(posedge clk) begin : drv
        t_date_req nxt;
        if (!rst_n) begin
            in_if.valid       <= 1'b0;
            in_if.start_day   <= '0;
            in_if.start_month <= '0;
            in_if.start_year  <= '0;
            in_if.days_to_add <= '0;
            in_gap            <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                due_q.push_back(advance_date('{in_if.start_day, in_if.start_month,
                                               in_if.start_year, in_if.days_to_add}));
            end
            if (in_gap != 0 || date_q.size() == 0) begin
                in_if.valid <= 1'b0;
                if (in_gap != 0) begin
                    in_gap <= in_gap - 1;
                end
            end else begin
                nxt = date_q.pop_front();
                in_if.valid       <= 1'b1;
                in_if.start_day   <= nxt.day;
                in_if.start_month <= nxt.month;
                in_if.start_year  <= nxt.year;
                in_if.days_to_add <= nxt.add;
                in_gap            <= pick_gap(n_offered);
                n_offered         <= n_offered + 1;
            end
        end
    end

    // receiver and checker
    always @(posedge clk) begin : mon
        t_date_res   want;
        int unsigned g;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            out_stall    <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_results <= n_results + 1;
                if (due_q.size() == 0) begin
                    $error("result transfer with no date pending");
                    err_cnt++;
                end else begin
                    want = due_q.pop_front();
                    if (out_if.result_day !== want.day) begin
                        $error("result_day: expected %0d, got %0d", want.day, out_if.result_day);
                        err_cnt++;
                    end
                    if (out_if.result_month !== want.month) begin
                        $error("result_month: expected %0d, got %0d",
                               want.month, out_if.result_month);
                        err_cnt++;
                    end
                    if (out_if.result_year !== want.year) begin
                        $error("result_year: expected %0d, got %0d",
                               want.year, out_if.result_year);
                        err_cnt++;
                    end
                    if (out_if.bad_date !== want.bad) begin
                        $error("bad_date: expected %0d, got %0d", want.bad, out_if.bad_date);
                        err_cnt++;
                    end
                end
            end
            if (hold_off) begin
                out_if.ready <= 1'b0;
            end else if (out_stall != 0) begin
                out_if.ready <= 1'b0;
                out_stall    <= out_stall - 1;
            end else begin
                g = (out_if.valid && out_if.ready) ? pick_gap(n_results) : 0;
                out_if.ready <= (g == 0);
                out_stall    <= (g == 0) ? 0 : g - 1;
            end
        end
    end

    // long back-pressure: output held off while the sender keeps offering
    initial begin
        wait (n_results >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin : stim
        int unsigned r;
        int unsigned mo;
        int unsigned yr;
        int unsigned len;
        int unsigned dy;
        int unsigned ad;
        rst_n = 1'b0;

        queue_date(1, GDA_JAN, 2024, 0);
        queue_date(31, GDA_DEC, 65535, 1);
        queue_date(29, GDA_FEB, 2024, 0);
        queue_date(29, GDA_FEB, 2023, 0);
        queue_date(29, GDA_FEB, 1900, 5);
        queue_date(29, GDA_FEB, 2000, 365);
        queue_date(29, GDA_FEB, 0, 0);
        queue_date(0, 5, 2020, 10);
        queue_date(1, 0, 2020, 10);
        queue_date(15, 13, 2020, 1);
        queue_date(31, 15, 65535, 65535);
        queue_date(31, 4, 2021, 0);
        queue_date(30, 4, 2021, 1);
        queue_date(31, GDA_DEC, 65535, 65535);
        queue_date(1, GDA_JAN, 0, 65535);
        queue_date(28, GDA_FEB, 2100, 1);
        queue_date(28, GDA_FEB, 2400, 1);
        queue_date(31, GDA_JAN, 2023, 29);
        queue_date(31, GDA_DEC, 1999, 0);
        queue_date(1, 3, 65535, 366);
        queue_date(15, 6, 30000, 12345);
        queue_date(30, 9, 1, 65535);
        queue_date(31, 7, 65534, 800);

        for (int i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                // raw fields, some of them invalid dates
                queue_date($urandom, $urandom, $urandom, $urandom);
            end else begin
                mo  = $urandom_range(GDA_JAN, GDA_DEC);
                yr  = (r < 30) ? $urandom_range(65530, 65535) : $urandom_range(0, 65535);
                len = days_in_month(mo, yr);
                dy  = (r % 5 == 0) ? len : $urandom_range(1, len);
                ad  = (r >= 82) ? $urandom_range(0, 65535) : $urandom_range(0, 1500);
                queue_date(dy, mo, yr, ad);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (date_q.size() != 0 || in_if.valid || due_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
